// ----- src/apic_mmio_pkg.sv -----
// apic_mmio_pkg: register offsets, select codes and fixed values of the APIC
// register window model. No dependencies; imported by apic_mmio_register_model_core.
package apic_mmio_pkg;

  // widths of the request fields
  localparam int unsigned AddrW  = 40;
  localparam int unsigned DataW  = 32;
  localparam int unsigned OffW   = 12;   // largest window is 4 KiB
  localparam int unsigned SlotW  = 5;    // entry number taken from the select value

  // local APIC register offsets
  localparam logic [OffW-1:0] OffLocalId    = 12'h020;
  localparam logic [OffW-1:0] OffLocalVer   = 12'h030;
  localparam logic [OffW-1:0] OffTaskPrio   = 12'h080;
  localparam logic [OffW-1:0] OffLogDest    = 12'h0D0;
  localparam logic [OffW-1:0] OffDestFmt    = 12'h0E0;
  localparam logic [OffW-1:0] OffSpurious   = 12'h0F0;
  localparam logic [OffW-1:0] OffCmdLow     = 12'h300;
  localparam logic [OffW-1:0] OffCmdHigh    = 12'h310;
  localparam logic [OffW-1:0] OffTimerLvt   = 12'h320;
  localparam logic [OffW-1:0] OffTimerInit  = 12'h380;
  localparam logic [OffW-1:0] OffTimerCur   = 12'h390;
  localparam logic [OffW-1:0] OffTimerDiv   = 12'h3E0;

  // I/O APIC window offsets
  localparam logic [OffW-1:0] OffIoSelect   = 12'h000;
  localparam logic [OffW-1:0] OffIoData     = 12'h010;

  // I/O APIC internal register select codes
  localparam logic [DataW-1:0] SelIoId      = 32'h0000_0000;
  localparam logic [DataW-1:0] SelIoVer     = 32'h0000_0001;
  localparam logic [DataW-1:0] SelRedirLo   = 32'h0000_0010;
  localparam logic [DataW-1:0] SelRedirHi   = 32'h0000_003F;

  // fixed values
  localparam logic [DataW-1:0] LocalVersion = 32'h0005_0014;
  localparam logic [DataW-1:0] SpuriousRst  = 32'h0000_01FF;
  localparam logic [DataW-1:0] IoIdRst      = 32'h0000_0001;
  localparam logic [DataW-1:0] IoVerLow     = 32'h0000_0020;
  localparam int unsigned      EnableBit    = 8;

  // configuration register indexes
  typedef enum logic {
    CFG_LOCAL_ID = 1'b0,
    CFG_NONE     = 1'b1
  } cfg_reg_e;

endpackage

// ----- src/apic_mmio_register_model_core.sv -----
// apic_mmio_register_model_core: local APIC and I/O APIC register windows
// behind a stream request port, with an APB port for the local APIC ID.
// Depends on apic_mmio_pkg.

// One request is taken per clock while the result stream is not stalled. It is
// held in an input register, then decoded and applied to the register file as
// it moves to an output register, where its answer lands. The answer is offered
// on the result stream from that output register. A steady stream runs at one
// request per cycle when the result stream does not stall; register updates
// from one request are seen by the very next one. The result stream may stall:
// while it does, at most two requests are held (one in each register) before
// the request stream is refused.
module apic_mmio_register_model_core #(
  parameter logic [39:0] LOCAL_BASE   = 40'd4276092928,
  parameter int unsigned LOCAL_WINDOW = 4096,
  parameter logic [39:0] IO_BASE      = 40'd4273995776,
  parameter int unsigned IO_WINDOW    = 4096,
  parameter int unsigned REDIR_COUNT  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [39:0] address, [71:40] write_data
  input  logic        s_axis_tuser,   // [0] cmd (0 read, 1 write)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_data, [32] apic_enabled, rest zero
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apic_mmio_pkg::*;

  localparam logic [AddrW:0] LocalLo = {1'b0, LOCAL_BASE};
  localparam logic [AddrW:0] LocalHi = {1'b0, LOCAL_BASE} + (AddrW+1)'(LOCAL_WINDOW);
  localparam logic [AddrW:0] IoLo    = {1'b0, IO_BASE};
  localparam logic [AddrW:0] IoHi    = {1'b0, IO_BASE} + (AddrW+1)'(IO_WINDOW);
  localparam int unsigned    IdxW    = (REDIR_COUNT > 1) ? $clog2(REDIR_COUNT) : 1;
  localparam logic [DataW-1:0] IoVersion =
      ((DataW'(REDIR_COUNT) - 32'd1) << 16) | IoVerLow;

  // configuration register
  logic [7:0] local_id_q;
  cfg_reg_e   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
    end else if (psel && penable && pwrite && (cfg_sel == CFG_LOCAL_ID)) begin
      local_id_q <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_LOCAL_ID: prdata = {24'd0, local_id_q};
      default:      prdata = '0;
    endcase
  end

  // input register
  logic             in_valid_q;
  logic             in_cmd_q;
  logic [AddrW-1:0] in_addr_q;
  logic [DataW-1:0] in_wdata_q;
  logic             out_valid_q;
  logic [DataW-1:0] out_rdata_q;
  logic             out_en_q;
  logic             adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q   <= s_axis_tuser;
      in_addr_q  <= s_axis_tdata[39:0];
      in_wdata_q <= s_axis_tdata[71:40];
    end
  end

  // register file
  logic [DataW-1:0] task_prio_q, log_dest_q, dest_fmt_q, spurious_q;
  logic [DataW-1:0] cmd_low_q, cmd_high_q, timer_lvt_q, timer_init_q;
  logic [DataW-1:0] timer_cur_q, timer_div_q, io_select_q, io_id_q;
  logic             sw_en_q;
  logic [63:0]      redir_q [REDIR_COUNT];

  // window decode
  logic [AddrW:0]   addr_x;
  logic             local_hit, io_hit;
  logic [OffW-1:0]  local_off, io_off;
  logic [SlotW-1:0] slot;
  logic             slot_ok;
  logic [IdxW-1:0]  redir_idx;
  logic             sel_hi;

  assign addr_x    = {1'b0, in_addr_q};
  assign local_hit = (addr_x >= LocalLo) && (addr_x < LocalHi);
  assign io_hit    = !local_hit && (addr_x >= IoLo) && (addr_x < IoHi);
  assign local_off = in_addr_q[OffW-1:0] - LOCAL_BASE[OffW-1:0];
  assign io_off    = in_addr_q[OffW-1:0] - IO_BASE[OffW-1:0];
  assign slot      = io_select_q[SlotW:1] - SlotW'(8);
  assign slot_ok   = (io_select_q >= SelRedirLo) && (io_select_q <= SelRedirHi)
                     && (32'(slot) < REDIR_COUNT);
  assign redir_idx = slot[IdxW-1:0];
  assign sel_hi    = io_select_q[0];

  // next register values and read data
  logic [DataW-1:0] rd;
  logic             wr;
  logic             we_tp, we_ld, we_df, we_sp, we_cl, we_ch, we_lvt, we_ti, we_td;
  logic             we_sel, we_ioid, we_redir;

  assign wr = in_cmd_q;

  always_comb begin
    rd       = '0;
    we_tp    = 1'b0;
    we_ld    = 1'b0;
    we_df    = 1'b0;
    we_sp    = 1'b0;
    we_cl    = 1'b0;
    we_ch    = 1'b0;
    we_lvt   = 1'b0;
    we_ti    = 1'b0;
    we_td    = 1'b0;
    we_sel   = 1'b0;
    we_ioid  = 1'b0;
    we_redir = 1'b0;
    if (local_hit) begin
      unique case (local_off)
        OffLocalId:   rd = {24'd0, local_id_q};
        OffLocalVer:  rd = LocalVersion;
        OffTaskPrio:  begin rd = task_prio_q;  we_tp  = wr; end
        OffLogDest:   begin rd = log_dest_q;   we_ld  = wr; end
        OffDestFmt:   begin rd = dest_fmt_q;   we_df  = wr; end
        OffSpurious:  begin rd = spurious_q;   we_sp  = wr; end
        OffCmdLow:    begin rd = cmd_low_q;    we_cl  = wr; end
        OffCmdHigh:   begin rd = cmd_high_q;   we_ch  = wr; end
        OffTimerLvt:  begin rd = timer_lvt_q;  we_lvt = wr; end
        OffTimerInit: begin rd = timer_init_q; we_ti  = wr; end
        OffTimerCur:  rd = timer_cur_q;
        OffTimerDiv:  begin rd = timer_div_q;  we_td  = wr; end
        default:      rd = '0;
      endcase
    end else if (io_hit) begin
      if (io_off == OffIoSelect) begin
        rd     = io_select_q;
        we_sel = wr;
      end else if (io_off == OffIoData) begin
        if (io_select_q == SelIoId) begin
          rd      = io_id_q;
          we_ioid = wr;
        end else if (io_select_q == SelIoVer) begin
          rd = IoVersion;
        end else if (slot_ok) begin
          rd       = sel_hi ? redir_q[redir_idx][63:32] : redir_q[redir_idx][31:0];
          we_redir = wr;
        end
      end
    end
  end

  // register updates, taken when the request moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_prio_q  <= '0;
      log_dest_q   <= '0;
      dest_fmt_q   <= '0;
      spurious_q   <= SpuriousRst;
      sw_en_q      <= 1'b1;
      cmd_low_q    <= '0;
      cmd_high_q   <= '0;
      timer_lvt_q  <= '0;
      timer_init_q <= '0;
      timer_cur_q  <= '0;
      timer_div_q  <= '0;
      io_select_q  <= '0;
      io_id_q      <= IoIdRst;
    end else if (adv) begin
      if (we_tp)   task_prio_q <= in_wdata_q;
      if (we_ld)   log_dest_q  <= in_wdata_q;
      if (we_df)   dest_fmt_q  <= in_wdata_q;
      if (we_sp) begin
        spurious_q <= in_wdata_q;
        sw_en_q    <= in_wdata_q[EnableBit];
      end
      if (we_cl)   cmd_low_q   <= in_wdata_q;
      if (we_ch)   cmd_high_q  <= in_wdata_q;
      if (we_lvt)  timer_lvt_q <= in_wdata_q;
      if (we_ti) begin
        timer_init_q <= in_wdata_q;
        timer_cur_q  <= in_wdata_q;
      end
      if (we_td)   timer_div_q <= in_wdata_q;
      if (we_sel)  io_select_q <= in_wdata_q;
      if (we_ioid) io_id_q     <= in_wdata_q;
    end
  end

  // redirection table, one 32-bit half written per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REDIR_COUNT; i++) begin
        redir_q[i] <= '0;
      end
    end else if (adv && we_redir) begin
      for (int i = 0; i < REDIR_COUNT; i++) begin
        if (redir_idx == IdxW'(i)) begin
          if (sel_hi) redir_q[i][63:32] <= in_wdata_q;
          else        redir_q[i][31:0]  <= in_wdata_q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rdata_q <= wr ? '0 : rd;
      out_en_q    <= we_sp ? in_wdata_q[EnableBit] : sw_en_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_en_q, out_rdata_q};

  // checks
  a_enable_tracks_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_en_q == spurious_q[EnableBit])
    else $error("software enable out of step with spurious vector bit");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_cmd_q |=> m_axis_tdata[31:0] == '0)
    else $error("write request returned non-zero read data");

  a_timer_counts_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && we_ti |=> timer_init_q == timer_cur_q)
    else $error("timer initial write did not load the current count");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("request refused while the input register is empty");

endmodule

// ----- tb/sv/tb_apic_mmio_register_model_core.sv -----
// tb_apic_mmio_register_model_core: self-checking bench for the APIC register windows,
// with a scoreboard that predicts each answer from a shadow register file.
// Depends on apic_mmio_pkg and apic_mmio_register_model_core.
module tb_apic_mmio_register_model_core;
  timeunit 1ns;
  timeprecision 1ps;

  import apic_mmio_pkg::*;

  // window placement, matching the block's defaults
  localparam logic [39:0] LocalBase   = 40'd4276092928;
  localparam logic [39:0] LocalWindow = 40'd4096;
  localparam logic [39:0] IoBase      = 40'd4273995776;
  localparam logic [39:0] IoWindow    = 40'd4096;
  localparam int unsigned RedirCount  = 24;
  localparam logic [31:0] IoVersion   = (32'(RedirCount - 1) << 16) | IoVerLow;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_e;

  typedef struct packed {
    logic [31:0] read_data;
    logic        apic_enabled;
  } apic_answer_t;

  // shadow register file and queue of answers still owed by the block
  class apic_window_scoreboard;
    logic [7:0]   local_id;
    logic [31:0]  task_priority, logical_dest, dest_format, spurious_vector;
    logic         sw_enable;
    logic [31:0]  icr_low, cmd_word_hi, timer_lvt, timer_load, timer_count, timer_div_cfg;
    logic [31:0]  io_select, io_id;
    logic [63:0]  redir [RedirCount];
    apic_answer_t pending_answers[$];
    int unsigned  failures;

    function new();
      local_id        = '0;
      task_priority   = '0;
      logical_dest    = '0;
      dest_format     = '0;
      spurious_vector = SpuriousRst;
      sw_enable       = 1'b1;
      icr_low         = '0;
      cmd_word_hi     = '0;
      timer_lvt       = '0;
      timer_load      = '0;
      timer_count     = '0;
      timer_div_cfg   = '0;
      io_select       = '0;
      io_id           = IoIdRst;
      foreach (redir[i]) redir[i] = '0;
      failures        = 0;
    endfunction

    function void set_local_id(logic [31:0] v);
      local_id = v[7:0];
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // local window: writes to unknown or read-only offsets fall through
    function logic [31:0] local_access(logic wr, logic [OffW-1:0] off, logic [31:0] v);
      if (wr) begin
        case (off)
          OffTaskPrio:  task_priority = v;
          OffLogDest:   logical_dest = v;
          OffDestFmt:   dest_format = v;
          OffSpurious: begin
            spurious_vector = v;
            sw_enable = v[EnableBit];
          end
          OffCmdLow:    icr_low = v;
          OffCmdHigh:   cmd_word_hi = v;
          OffTimerLvt:  timer_lvt = v;
          OffTimerInit: begin
            timer_load  = v;
            timer_count = v;
          end
          OffTimerDiv:  timer_div_cfg = v;
          default: ;
        endcase
        return '0;
      end
      case (off)
        OffLocalId:   return {24'h0, local_id};
        OffLocalVer:  return LocalVersion;
        OffTaskPrio:  return task_priority;
        OffLogDest:   return logical_dest;
        OffDestFmt:   return dest_format;
        OffSpurious:  return spurious_vector;
        OffCmdLow:    return icr_low;
        OffCmdHigh:   return cmd_word_hi;
        OffTimerLvt:  return timer_lvt;
        OffTimerInit: return timer_load;
        OffTimerCur:  return timer_count;
        OffTimerDiv:  return timer_div_cfg;
        default:      return '0;
      endcase
    endfunction

    // indirect data window, steered by the select register
    function logic [31:0] io_data_access(logic wr, logic [31:0] v);
      logic [31:0] slot;
      if (io_select == SelIoId) begin
        if (wr) io_id = v;
        else return io_id;
      end else if (io_select == SelIoVer) begin
        if (!wr) return IoVersion;
      end else if (io_select >= SelRedirLo && io_select <= SelRedirHi) begin
        slot = (io_select - SelRedirLo) >> 1;
        if (slot < RedirCount) begin
          if (wr && io_select[0]) redir[slot][63:32] = v;
          else if (wr) redir[slot][31:0] = v;
          else return io_select[0] ? redir[slot][63:32] : redir[slot][31:0];
        end
      end
      return '0;
    endfunction

    function void note_request(access_e cmd, logic [39:0] addr, logic [31:0] v);
      apic_answer_t ans;
      logic         wr;
      logic [31:0]  rd;
      wr = (cmd == ACC_WRITE);
      rd = '0;
      // local window wins where the two overlap
      if (addr >= LocalBase && addr < LocalBase + LocalWindow) begin
        rd = local_access(wr, OffW'(addr - LocalBase), v);
      end else if (addr >= IoBase && addr < IoBase + IoWindow) begin
        if (OffW'(addr - IoBase) == OffIoSelect) begin
          if (wr) io_select = v;
          else rd = io_select;
        end else if (OffW'(addr - IoBase) == OffIoData) begin
          rd = io_data_access(wr, v);
        end
      end
      ans.read_data    = wr ? '0 : rd;
      ans.apic_enabled = sw_enable;
      pending_answers.push_back(ans);
    endfunction

    function void check_result(logic [31:0] rd, logic en);
      apic_answer_t ans;
      if (pending_answers.size() == 0) begin
        flag($sformatf("answer with no request waiting: read_data %h enabled %b", rd, en));
        return;
      end
      ans = pending_answers.pop_front();
      if (ans.read_data !== rd)
        flag($sformatf("read_data expected %h got %h", ans.read_data, rd));
      if (ans.apic_enabled !== en)
        flag($sformatf("apic_enabled expected %b got %b", ans.apic_enabled, en));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // [39:0] address, [71:40] write_data
  logic        s_axis_tuser;   // [0] cmd (0 read, 1 write)
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] read_data, [32] apic_enabled, rest zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  apic_window_scoreboard board;
  bit          idle_on;
  bit          hold_request;
  int unsigned sent_items;

  apic_mmio_register_model_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata[31:0], m_axis_tdata[32]);
    end
  end

  // offer one request, with an occasional gap before it
  task automatic send_request(access_e cmd, logic [39:0] addr, logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(cmd, addr, v);
    sent_items++;
  endtask

  // stop offering and let every owed answer come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup and access cycle on the configuration port
  task automatic write_local_id(logic [7:0] id);
    logic [31:0] v;
    v = {$urandom_range(0, 1) ? 24'($urandom) : 24'h0, id};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_LOCAL_ID, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_local_id(v);
  endtask

  function automatic logic [OffW-1:0] local_reg_offset(int unsigned i);
    case (i)
      0:       return OffLocalId;
      1:       return OffLocalVer;
      2:       return OffTaskPrio;
      3:       return OffLogDest;
      4:       return OffDestFmt;
      5:       return OffSpurious;
      6:       return OffCmdLow;
      7:       return OffCmdHigh;
      8:       return OffTimerLvt;
      9:       return OffTimerInit;
      10:      return OffTimerCur;
      default: return OffTimerDiv;
    endcase
  endfunction

  // mostly real registers and select-then-data sequences, some noise
  task automatic random_request();
    int unsigned pick;
    logic [31:0] sel;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_request(access_e'($urandom_range(0, 1)),
                   LocalBase + 40'(local_reg_offset($urandom_range(0, 11))), $urandom);
    end else if (pick < 75) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       sel = SelRedirLo + $urandom_range(0, 2 * RedirCount - 1);
      else if (pick == 6) sel = SelIoId;
      else if (pick == 7) sel = SelIoVer;
      else if (pick == 8) sel = $urandom_range(2, 15);
      else                sel = $urandom;
      send_request(ACC_WRITE, IoBase + 40'(OffIoSelect), sel);
      repeat ($urandom_range(1, 3))
        send_request(access_e'($urandom_range(0, 1)), IoBase + 40'(OffIoData), $urandom);
    end else if (pick < 85) begin
      send_request(access_e'($urandom_range(0, 1)), LocalBase + 40'(OffW'($urandom)), $urandom);
    end else if (pick < 92) begin
      send_request(access_e'($urandom_range(0, 1)),
                   IoBase + 40'($urandom_range(0, 1) ? OffIoSelect : OffW'($urandom)), $urandom);
    end else begin
      send_request(access_e'($urandom_range(0, 1)), {8'($urandom), 32'($urandom)}, $urandom);
    end
  endtask

  // main sequence
  initial begin
    board         = new();
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    sent_items    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACC_READ;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, enable bit, read-only registers, timer load
    send_request(ACC_READ,  LocalBase + 40'(OffLocalId),   '0);
    send_request(ACC_READ,  LocalBase + 40'(OffLocalVer),  '0);
    send_request(ACC_READ,  LocalBase + 40'(OffSpurious),  '0);
    send_request(ACC_WRITE, LocalBase + 40'(OffSpurious),  32'h0000_00FF);
    send_request(ACC_READ,  LocalBase + 40'(OffSpurious),  '1);
    send_request(ACC_WRITE, LocalBase + 40'(OffSpurious),  32'hFFFF_FFFF);
    send_request(ACC_WRITE, LocalBase + 40'(OffTaskPrio),  32'hFFFF_FFFF);
    send_request(ACC_READ,  LocalBase + 40'(OffTaskPrio),  '0);
    send_request(ACC_WRITE, LocalBase + 40'(OffLocalId),   32'hFFFF_FFFF);
    send_request(ACC_WRITE, LocalBase + 40'(OffLocalVer),  32'hFFFF_FFFF);
    send_request(ACC_WRITE, LocalBase + 40'(OffTimerCur),  32'h0000_1234);
    send_request(ACC_WRITE, LocalBase + 40'(OffTimerInit), 32'hDEAD_BEEF);
    send_request(ACC_READ,  LocalBase + 40'(OffTimerCur),  '0);
    // unmapped local offset (end of interrupt) and unmapped I/O offset
    send_request(ACC_WRITE, LocalBase + 40'(12'h0B0),      32'hFFFF_FFFF);
    send_request(ACC_READ,  LocalBase + 40'(12'h0B0),      '0);
    send_request(ACC_READ,  IoBase + 40'(12'h020),         '0);
    // indirect window: id, version, last entry high half, out-of-range select
    send_request(ACC_READ,  IoBase + 40'(OffIoData),       '0);
    send_request(ACC_WRITE, IoBase + 40'(OffIoData),       32'hFFFF_FFFF);
    send_request(ACC_WRITE, IoBase + 40'(OffIoSelect),     SelIoVer);
    send_request(ACC_WRITE, IoBase + 40'(OffIoData),       32'h5555_AAAA);
    send_request(ACC_READ,  IoBase + 40'(OffIoData),       '0);
    send_request(ACC_WRITE, IoBase + 40'(OffIoSelect),     SelRedirHi);
    send_request(ACC_WRITE, IoBase + 40'(OffIoData),       32'hCAFE_F00D);
    send_request(ACC_READ,  IoBase + 40'(OffIoData),       '0);
    send_request(ACC_WRITE, IoBase + 40'(OffIoSelect),     SelRedirHi + 32'd1);
    send_request(ACC_READ,  IoBase + 40'(OffIoData),       '0);
    send_request(ACC_READ,  40'h00_0000_0000,              '0);
    send_request(ACC_READ,  40'hFF_FFFF_FFFF,              '0);

    // largest local id, random traffic
    wait_drained();
    write_local_id(8'hFF);
    while (sent_items < 350) random_request();

    // random id, then a long stall on the result side while requests pile up
    wait_drained();
    write_local_id(8'($urandom));
    hold_request = 1'b1;
    while (sent_items < 450) random_request();

    // sender pauses until everything is back, then smallest id
    wait_drained();
    write_local_id(8'h00);
    while (sent_items < 850) random_request();

    // closing stretch without gaps on either side
    idle_on = 1'b0;
    while (sent_items < 1050) random_request();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
